@@ rtl/sbrd_pkg.sv @@
// Shared constants for the SHiP/BRRIP set-dueling replacement block.
package sbrd_pkg;

  // Default configuration of the replacement block.
  localparam int NUM_SETS_DEF       = 2048;
  localparam int NUM_WAYS_DEF       = 16;
  localparam int SIGNATURE_BITS_DEF = 14;
  localparam int LEADER_GROUPS_DEF  = 64;
  localparam int SELECTOR_BITS_DEF  = 10;
  localparam int RRPV_WIDTH_DEF     = 2;

  // Fixed port field widths.
  localparam int SET_IN_W   = 11;
  localparam int WAY_IN_W   = 4;
  localparam int PC_W       = 64;
  localparam int COIN_W     = 5;
  localparam int RRPV_OUT_W = 2;
  localparam int SEL_OUT_W  = 10;

  // The signature starts above the instruction alignment bits of the PC.
  localparam int PC_SIG_LSB = 2;

  // Signature counters are 4-bit saturating counters split into four bands.
  localparam int             CTR_W     = 4;
  localparam logic [CTR_W-1:0] CTR_TOP   = 4'd15;
  localparam logic [CTR_W-1:0] CTR_RESET = 4'd8;
  localparam logic [CTR_W-1:0] BAND_LOW  = 4'd4;
  localparam logic [CTR_W-1:0] BAND_MID  = 4'd8;
  localparam logic [CTR_W-1:0] BAND_HIGH = 4'd12;

endpackage

@@ rtl/sbrd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module sbrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/sbrd_victim.sv @@
// Ages the RRPVs of one set and finds the lowest way at the distant RRPV.
module sbrd_victim
  import sbrd_pkg::*;
#(
  parameter int NUM_WAYS   = NUM_WAYS_DEF,
  parameter int RRPV_WIDTH = RRPV_WIDTH_DEF
) (
  input  logic [NUM_WAYS-1:0][RRPV_WIDTH-1:0] rrpv_row,
  output logic [NUM_WAYS-1:0][RRPV_WIDTH-1:0] aged_row,
  output logic [$clog2(NUM_WAYS)-1:0]         victim_way
);

  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int LEVELS = 1 << RRPV_WIDTH;
  localparam logic [RRPV_WIDTH-1:0] RRPV_TOP = RRPV_WIDTH'(LEVELS - 1);

  logic [LEVELS-1:0]     present;
  logic [RRPV_WIDTH-1:0] top_lvl;
  logic [RRPV_WIDTH-1:0] lift;

  // Mark which RRPV levels occur in the set, then take the highest one.
  always_comb begin
    present = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      present[rrpv_row[w]] = 1'b1;
    end
    top_lvl = '0;
    for (int k = 0; k < LEVELS; k++) begin
      if (present[k]) begin
        top_lvl = RRPV_WIDTH'(k);
      end
    end
    lift = RRPV_TOP - top_lvl;
  end

  // Age every way by the lift that brings the oldest way to the top, saturating.
  always_comb begin
    logic [RRPV_WIDTH:0] sum;
    for (int w = 0; w < NUM_WAYS; w++) begin
      sum = {1'b0, rrpv_row[w]} + {1'b0, lift};
      aged_row[w] = (sum > {1'b0, RRPV_TOP}) ? RRPV_TOP : sum[RRPV_WIDTH-1:0];
    end
  end

  // The victim is the lowest-numbered way that held the oldest level.
  always_comb begin
    logic found;
    found = 1'b0;
    victim_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && rrpv_row[w] == top_lvl) begin
        victim_way = WAY_W'(w);
        found = 1'b1;
      end
    end
  end

endmodule

@@ rtl/ship_brrip_dueling_replacement.sv @@
// Top level: SHiP insertion with BRRIP set dueling around a set-row memory.
// A hit reads its set row and writes it back with the result; a miss adds a training
// step for the second signature-counter read that trains the evicted line.
// Items are taken one at a time, each held until its read-modify-write of the set row
// and the counter memory port is done and the output is free to take its result.
// After reset a clearing pass over max(NUM_SETS, 2**SIGNATURE_BITS) addresses (16384 at
// the defaults) initializes both memories; no input transfer is taken meanwhile.
module ship_brrip_dueling_replacement
  import sbrd_pkg::*;
#(
  parameter int NUM_SETS       = NUM_SETS_DEF,        // power of two
  parameter int NUM_WAYS       = NUM_WAYS_DEF,
  parameter int SIGNATURE_BITS = SIGNATURE_BITS_DEF,
  parameter int LEADER_GROUPS  = LEADER_GROUPS_DEF,   // power of two
  parameter int SELECTOR_BITS  = SELECTOR_BITS_DEF,
  parameter int RRPV_WIDTH     = RRPV_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SET_IN_W-1:0]   in_set_index,
  input  logic                  in_is_hit,
  input  logic [WAY_IN_W-1:0]   in_hit_way,
  input  logic [PC_W-1:0]       in_access_pc,
  input  logic [COIN_W-1:0]     in_coin_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WAY_IN_W-1:0]   out_chosen_way,
  output logic [RRPV_OUT_W-1:0] out_new_rrpv,
  output logic                  out_used_ship,
  output logic [SEL_OUT_W-1:0]  out_selector_value
);

  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int SIG_COUNT = 1 << SIGNATURE_BITS;
  localparam int ROW_W     = NUM_WAYS * (RRPV_WIDTH + 2 + SIGNATURE_BITS);
  localparam int CLEAR_LEN = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
  localparam int CLR_W     = $clog2(CLEAR_LEN);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLEAR_LEN - 1);

  localparam logic [RRPV_WIDTH-1:0] RRPV_TOP  = RRPV_WIDTH'((1 << RRPV_WIDTH) - 1);
  localparam logic [RRPV_WIDTH-1:0] RRPV_NEAR = RRPV_WIDTH'((1 << RRPV_WIDTH) - 2);
  localparam logic [RRPV_WIDTH-1:0] RRPV_MID  = RRPV_WIDTH'((1 << RRPV_WIDTH) - 3);

  localparam logic [SELECTOR_BITS-1:0] SEL_TOP = SELECTOR_BITS'((1 << SELECTOR_BITS) - 1);
  localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_TOP >> 1;

  localparam int PERIOD_RAW = NUM_SETS / LEADER_GROUPS;
  localparam int PERIOD     = (PERIOD_RAW < 1) ? 1 : PERIOD_RAW;
  localparam int PERIOD_SH  = $clog2(PERIOD);
  localparam logic [SET_W-1:0] PERIOD_MASK = SET_W'(PERIOD - 1);
  localparam logic [31:0] HALF_GROUPS = 32'(LEADER_GROUPS / 2);
  localparam logic [31:0] ALL_GROUPS  = 32'(LEADER_GROUPS);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_ROW, ST_TRAIN} state_t;
  typedef enum logic [1:0] {LEAD_NONE, LEAD_SHIP, LEAD_BRRIP} lead_t;

  typedef logic [NUM_WAYS-1:0][RRPV_WIDTH-1:0]     rrpv_row_t;
  typedef logic [NUM_WAYS-1:0][SIGNATURE_BITS-1:0] sig_row_t;

  // Hit way taken modulo the associativity by repeated subtraction.
  function automatic logic [WAY_W-1:0] way_mod(input logic [WAY_IN_W-1:0] w);
    logic [5:0] v;
    v = 6'(w);
    for (int i = 0; i < 8; i++) begin
      if (v >= 6'(NUM_WAYS)) begin
        v = v - 6'(NUM_WAYS);
      end
    end
    return WAY_W'(v);
  endfunction

  // Registers.
  state_t                    state_r, state_nxt;
  logic [CLR_W-1:0]          clr_idx_r, clr_idx_nxt;
  logic [SELECTOR_BITS-1:0]  sel_r, sel_nxt;
  logic [SET_W-1:0]          set_r, set_nxt;
  logic                      hit_r, hit_nxt;
  logic [WAY_W-1:0]          way_r, way_nxt;
  logic [SIGNATURE_BITS-1:0] sig_r, sig_nxt;
  logic                      coin_zero_r, coin_zero_nxt;
  rrpv_row_t                 aged_r, aged_nxt;
  logic [WAY_W-1:0]          victim_r, victim_nxt;
  logic                      ship_r, ship_nxt;
  logic [CTR_W-1:0]          ctr_new_r, ctr_new_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [WAY_IN_W-1:0]       out_way_r, out_way_nxt;
  logic [RRPV_OUT_W-1:0]     out_rrpv_r, out_rrpv_nxt;
  logic                      out_ship_r, out_ship_nxt;
  logic [SEL_OUT_W-1:0]      out_sel_r, out_sel_nxt;

  // Memory ports.
  logic                      row_we, row_re;
  logic [SET_W-1:0]          row_waddr, row_raddr;
  logic [ROW_W-1:0]          row_wdata, row_rdata;
  logic                      ctr_we, ctr_re;
  logic [SIGNATURE_BITS-1:0] ctr_waddr, ctr_raddr;
  logic [CTR_W-1:0]          ctr_wdata, ctr_rdata;

  // Row fields as read and as written back.
  rrpv_row_t                 rd_rrpv, wr_rrpv, hit_rrpv, miss_rrpv, vic_aged;
  logic [NUM_WAYS-1:0]       rd_ref, rd_trn, hit_ref, miss_ref, miss_trn;
  sig_row_t                  rd_sig, miss_sig;
  logic [WAY_W-1:0]          vic_way;

  logic                      out_free;
  lead_t                     lead;
  logic [SET_W-1:0]          group;
  logic                      miss_ship;
  logic [SELECTOR_BITS-1:0]  sel_upd;
  logic [SIGNATURE_BITS-1:0] old_sig;
  logic                      old_trn, old_ref;
  logic [CTR_W-1:0]          trained, ctr_eff;
  logic [RRPV_WIDTH-1:0]     ins_value;

  assign {rd_sig, rd_trn, rd_ref, rd_rrpv} = row_rdata;

  // Set rows: RRPVs, referenced bits, trainable bits and stored signatures.
  sbrd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // Signature outcome counters.
  sbrd_ram #(
    .WIDTH (CTR_W),
    .DEPTH (SIG_COUNT)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .re    (ctr_re),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  sbrd_victim #(
    .NUM_WAYS   (NUM_WAYS),
    .RRPV_WIDTH (RRPV_WIDTH)
  ) u_victim (
    .rrpv_row   (rd_rrpv),
    .aged_row   (vic_aged),
    .victim_way (vic_way)
  );

  assign out_free = !out_valid_r || !out_stall;

  // Hit update: the way gets RRPV 0 and is marked referenced.
  always_comb begin
    hit_rrpv = rd_rrpv;
    hit_ref  = rd_ref;
    hit_rrpv[way_r] = '0;
    hit_ref[way_r]  = 1'b1;
  end

  // Leader classification and selector update of a miss.
  always_comb begin
    group = set_r >> PERIOD_SH;
    lead  = LEAD_NONE;
    if ((set_r & PERIOD_MASK) == '0) begin
      if (32'(group) < HALF_GROUPS) begin
        lead = LEAD_SHIP;
      end else if (32'(group) < ALL_GROUPS) begin
        lead = LEAD_BRRIP;
      end
    end
    sel_upd   = sel_r;
    miss_ship = (sel_r >= SEL_MID);
    case (lead)
      LEAD_SHIP: begin
        miss_ship = 1'b1;
        if (sel_r != '0) begin
          sel_upd = sel_r - 1'b1;
        end
      end
      LEAD_BRRIP: begin
        miss_ship = 1'b0;
        if (sel_r != SEL_TOP) begin
          sel_upd = sel_r + 1'b1;
        end
      end
      default: begin
        sel_upd = sel_r;
      end
    endcase
  end

  // Training of the evicted line's counter and insertion of the new line.
  always_comb begin
    old_sig = rd_sig[victim_r];
    old_trn = rd_trn[victim_r];
    old_ref = rd_ref[victim_r];
    trained = ctr_rdata;
    if (old_ref) begin
      if (ctr_rdata != CTR_TOP) begin
        trained = ctr_rdata + 1'b1;
      end
    end else if (ctr_rdata != '0) begin
      trained = ctr_rdata - 1'b1;
    end
    // The new signature sees the trained value when it is the same counter.
    ctr_eff = (old_trn && old_sig == sig_r) ? trained : ctr_new_r;
    if (ship_r) begin
      if (ctr_eff < BAND_LOW) begin
        ins_value = RRPV_TOP;
      end else if (ctr_eff < BAND_MID) begin
        ins_value = RRPV_NEAR;
      end else if (ctr_eff < BAND_HIGH) begin
        ins_value = RRPV_MID;
      end else begin
        ins_value = '0;
      end
    end else begin
      ins_value = coin_zero_r ? RRPV_NEAR : RRPV_TOP;
    end
    miss_rrpv = aged_r;
    miss_sig  = rd_sig;
    miss_ref  = rd_ref;
    miss_trn  = rd_trn;
    miss_rrpv[victim_r] = ins_value;
    miss_trn[victim_r]  = ship_r;
    if (ship_r) begin
      miss_sig[victim_r] = sig_r;
      miss_ref[victim_r] = 1'b0;
    end
  end

  // Sequencer: clearing pass, then read, modify and write back per item.
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    sel_nxt       = sel_r;
    set_nxt       = set_r;
    hit_nxt       = hit_r;
    way_nxt       = way_r;
    sig_nxt       = sig_r;
    coin_zero_nxt = coin_zero_r;
    aged_nxt      = aged_r;
    victim_nxt    = victim_r;
    ship_nxt      = ship_r;
    ctr_new_nxt   = ctr_new_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_way_nxt   = out_way_r;
    out_rrpv_nxt  = out_rrpv_r;
    out_ship_nxt  = out_ship_r;
    out_sel_nxt   = out_sel_r;

    row_we    = 1'b0;
    row_re    = 1'b0;
    row_waddr = set_r;
    row_raddr = SET_W'(in_set_index);
    wr_rrpv   = hit_rrpv;
    row_wdata = {rd_sig, rd_trn, hit_ref, hit_rrpv};
    ctr_we    = 1'b0;
    ctr_re    = 1'b0;
    ctr_waddr = old_sig;
    ctr_raddr = in_access_pc[PC_SIG_LSB +: SIGNATURE_BITS];
    ctr_wdata = trained;

    case (state_r)
      ST_CLEAR: begin
        wr_rrpv   = {NUM_WAYS{RRPV_TOP}};
        row_we    = 1'b1;
        row_waddr = clr_idx_r[SET_W-1:0];
        row_wdata = {sig_row_t'('0), {NUM_WAYS{1'b0}}, {NUM_WAYS{1'b0}}, wr_rrpv};
        ctr_we    = 1'b1;
        ctr_waddr = clr_idx_r[SIGNATURE_BITS-1:0];
        ctr_wdata = CTR_RESET;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          row_re        = 1'b1;
          ctr_re        = 1'b1;
          set_nxt       = SET_W'(in_set_index);
          hit_nxt       = in_is_hit;
          way_nxt       = way_mod(in_hit_way);
          sig_nxt       = in_access_pc[PC_SIG_LSB +: SIGNATURE_BITS];
          coin_zero_nxt = (in_coin_bits == '0);
          state_nxt     = ST_ROW;
        end
      end
      ST_ROW: begin
        if (hit_r) begin
          if (out_free) begin
            row_we        = 1'b1;
            out_valid_nxt = 1'b1;
            out_way_nxt   = WAY_IN_W'(way_r);
            out_rrpv_nxt  = '0;
            out_ship_nxt  = 1'b0;
            out_sel_nxt   = SEL_OUT_W'(sel_r);
            state_nxt     = ST_IDLE;
          end
        end else begin
          // Victim found; fetch the evicted line's counter for training.
          ctr_re      = 1'b1;
          ctr_raddr   = rd_sig[vic_way];
          ctr_new_nxt = ctr_rdata;
          aged_nxt    = vic_aged;
          victim_nxt  = vic_way;
          ship_nxt    = miss_ship;
          sel_nxt     = sel_upd;
          state_nxt   = ST_TRAIN;
        end
      end
      ST_TRAIN: begin
        wr_rrpv   = miss_rrpv;
        row_wdata = {miss_sig, miss_trn, miss_ref, wr_rrpv};
        if (out_free) begin
          row_we        = 1'b1;
          ctr_we        = old_trn;
          out_valid_nxt = 1'b1;
          out_way_nxt   = WAY_IN_W'(victim_r);
          out_rrpv_nxt  = RRPV_OUT_W'(ins_value);
          out_ship_nxt  = ship_r;
          out_sel_nxt   = SEL_OUT_W'(sel_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, control and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      sel_r       <= SEL_MID;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
    set_r       <= set_nxt;
    hit_r       <= hit_nxt;
    way_r       <= way_nxt;
    sig_r       <= sig_nxt;
    coin_zero_r <= coin_zero_nxt;
    aged_r      <= aged_nxt;
    victim_r    <= victim_nxt;
    ship_r      <= ship_nxt;
    ctr_new_r   <= ctr_new_nxt;
    out_way_r   <= out_way_nxt;
    out_rrpv_r  <= out_rrpv_nxt;
    out_ship_r  <= out_ship_nxt;
    out_sel_r   <= out_sel_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_chosen_way     = out_way_r;
  assign out_new_rrpv       = out_rrpv_r;
  assign out_used_ship      = out_ship_r;
  assign out_selector_value = out_sel_r;

  // An accepted transfer always moves on to the row read.
  a_accept_to_row: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_ROW))
    else $error("accepted item did not reach the row stage");

  // Only a miss goes through the training step.
  a_train_only_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRAIN) |-> !hit_r)
    else $error("hit item entered the training step");

  // A hit never moves the policy selector.
  a_hit_keeps_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW && hit_r) |=> $stable(sel_r))
    else $error("selector changed on a hit");

  // Counters are written only by the clearing pass or by training.
  a_ctr_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ctr_we |-> (state_r == ST_CLEAR || state_r == ST_TRAIN))
    else $error("counter write outside clearing or training");

endmodule
